@@ rtl/core/ipv4lpm_pkg.sv @@
package ipv4lpm_pkg;

   localparam int ROUTE_ENTRIES_DEF = 64;

   localparam int ADDR_W    = 32;
   localparam int PLEN_W    = 6;
   localparam int WORD_W    = 16;
   localparam int TTL_W     = 8;
   localparam int WIDX_W    = 5;
   localparam int IHL_W     = 4;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 56;

   localparam logic [PLEN_W-1:0] PLEN_MAX  = PLEN_W'(32);
   localparam logic [WIDX_W-1:0] WIDX_SAT  = WIDX_W'(31);
   localparam logic [WIDX_W-1:0] IDX_IHL   = WIDX_W'(0);
   localparam logic [WIDX_W-1:0] IDX_TTL   = WIDX_W'(4);
   localparam logic [WIDX_W-1:0] IDX_CSUM  = WIDX_W'(5);
   localparam logic [WIDX_W-1:0] IDX_DST_H = WIDX_W'(8);
   localparam logic [WIDX_W-1:0] IDX_DST_L = WIDX_W'(9);
   localparam logic [WORD_W-1:0] CSUM_MAX  = 16'hFFFF;
   localparam logic [WORD_W-1:0] TTL_ONE   = 16'h0100;

   typedef enum logic {
      FUNC_ADD_ROUTE = 1'b0,
      FUNC_HDR_WORD  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      VERDICT_LOCAL    = 2'd0,
      VERDICT_TTL_ERR  = 2'd1,
      VERDICT_NO_ROUTE = 2'd2,
      VERDICT_FORWARD  = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] hop;
      logic [PLEN_W-1:0] len;
      logic [ADDR_W-1:0] prefix;
   } route_type;

   function automatic logic [ADDR_W-1:0] mask_of(input logic [PLEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      begin
         if (len == '0) begin
            m = '0;
         end else if (len >= PLEN_MAX) begin
            m = '1;
         end else begin
            m = ~({ADDR_W{1'b1}} >> len);
         end
         return m;
      end
   endfunction

endpackage

@@ rtl/core/ipv4lpm_ram.sv @@
module ipv4lpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ipv4_longest_prefix_forwarder_unit.sv @@
// IPv4 longest-prefix-match forwarder.
// req channel: tuser selects the beat kind (0 add route, 1 header word).
//   An add beat writes the next free route slot; adds to a full table are
//   dropped. Header words stream one per cycle while req_tready is high,
//   tlast on the final word. Words past 2*IHL do not enter the checksum.
// rsp channel: one beat per header, carrying verdict in tuser and
//   next hop / decremented TTL / new checksum in tdata (zero unless forwarding).
// Sweep: after the last header word the route table RAM is swept one entry
//   per cycle; local delivery and TTL error skip the sweep, and an empty
//   table has no entries to read. req_tready is low during the sweep.
// Throughput: one add or header word per cycle while req_tready is high.
// The result sits in an output register; a stalled rsp side only blocks the
//   block once the next header's sweep is done.
// csr_wr_en writes local_address; write it only while the block is idle.
// Reset (synchronous) empties the table, clears local_address and drops any
//   partial header. The table RAM is not cleared; only entries below the
//   route count are read.
module ipv4_longest_prefix_forwarder_unit
   import ipv4lpm_pkg::*;
#(
   parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [ADDR_W-1:0]     csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // route_prefix[31:0], route_prefix_len[37:32], route_next_hop[69:38],
   // header_word[85:70], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // next_hop[31:0], new_ttl[39:32], new_checksum[55:40]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // verdict
   output logic [1:0]            rsp_tuser
);
   localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int CW = $clog2(ROUTE_ENTRIES + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(ROUTE_ENTRIES);

   // request fields
   logic [ADDR_W-1:0] in_prefix, in_hop;
   logic [PLEN_W-1:0] in_len, in_len_sat;
   logic [WORD_W-1:0] in_word;
   logic              accept, is_add, is_hdr;

   assign in_prefix = req_tdata[31:0];
   assign in_len    = req_tdata[37:32];
   assign in_hop    = req_tdata[69:38];
   assign in_word   = req_tdata[85:70];
   assign in_len_sat = (in_len > PLEN_MAX) ? PLEN_MAX : in_len;

   assign accept = req_tvalid && req_tready;
   assign is_add = accept && (func_type'(req_tuser) == FUNC_ADD_ROUTE);
   assign is_hdr = accept && (func_type'(req_tuser) == FUNC_HDR_WORD);

   // state
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] local_addr_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic [IHL_W-1:0]  ihl_ff, ihl_in;
   logic [TTL_W-1:0]  ttl_ff, ttl_in;
   logic [ADDR_W-1:0] dest_ff, dest_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              found_ff, found_in;
   logic [PLEN_W-1:0] best_len_ff, best_len_in;
   logic [ADDR_W-1:0] best_hop_ff, best_hop_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   verdict_type       rsp_verdict_ff, rsp_verdict_in;

   // FSM controls
   logic skip, scan_issue, scan_done, result_load, out_free;

   // RAM
   route_type         wr_route, rd_route;
   logic              ram_we;

   assign wr_route = '{hop: in_hop, len: in_len_sat, prefix: in_prefix};
   assign ram_we   = is_add && (count_ff < COUNT_FULL);

   ipv4lpm_ram #(
      .WIDTH($bits(route_type)),
      .DEPTH(ROUTE_ENTRIES)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_route),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_route)
   );

   assign skip      = (dest_ff == local_addr_ff) || (ttl_ff == '0);
   assign scan_done = (skip || (scan_ff == count_ff)) && !rd_vld_ff;
   assign out_free  = !rsp_vld_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (is_hdr && req_tlast) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready  = 1'b0;
      scan_issue  = 1'b0;
      result_load = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_tready  = 1'b1;
         S_SCAN:   scan_issue  = !skip && (scan_ff != count_ff);
         S_RESULT: result_load = out_free;
         default:  req_tready  = 1'b0;
      endcase
   end

   // header accumulation
   logic [IHL_W-1:0]  ihl_cur;
   logic [WORD_W-1:0] sum_word;
   logic [WORD_W:0]   sum_wide;
   logic              sum_take;

   always_comb begin
      ihl_cur  = (widx_ff == IDX_IHL) ? in_word[11:8] : ihl_ff;
      sum_take = (widx_ff < {ihl_cur, 1'b0}) && (widx_ff != IDX_CSUM);
      sum_word = in_word;
      if ((widx_ff == IDX_TTL) && (in_word[15:8] != '0)) begin
         sum_word = in_word - TTL_ONE;
      end
      sum_wide = {1'b0, sum_ff} + {1'b0, sum_word};
      if (sum_wide > {1'b0, CSUM_MAX}) begin
         sum_wide = sum_wide - {1'b0, CSUM_MAX};
      end
   end

   // route compare on the registered RAM output
   logic rt_match, rt_better;

   assign rt_match  = ((dest_ff ^ rd_route.prefix) & mask_of(rd_route.len)) == '0;
   assign rt_better = rd_vld_ff && rt_match && (!found_ff || (rd_route.len > best_len_ff));

   always_comb begin
      count_in    = ram_we ? count_ff + CW'(1) : count_ff;
      widx_in     = widx_ff;
      ihl_in      = ihl_ff;
      ttl_in      = ttl_ff;
      dest_in     = dest_ff;
      sum_in      = sum_ff;
      scan_in     = scan_ff;
      rd_vld_in   = scan_issue;
      found_in    = found_ff;
      best_len_in = best_len_ff;
      best_hop_in = best_hop_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_verdict_in = rsp_verdict_ff;

      if (is_hdr) begin
         ihl_in = ihl_cur;
         if (widx_ff == IDX_TTL)   ttl_in = in_word[15:8];
         if (widx_ff == IDX_DST_H) dest_in[31:16] = in_word;
         if (widx_ff == IDX_DST_L) dest_in[15:0] = in_word;
         if (sum_take) sum_in = sum_wide[WORD_W-1:0];
         if (widx_ff != WIDX_SAT) widx_in = widx_ff + WIDX_W'(1);
         if (req_tlast) begin
            scan_in  = '0;
            found_in = 1'b0;
         end
      end

      if (scan_issue) begin
         scan_in = scan_ff + CW'(1);
      end
      if (rt_better) begin
         found_in    = 1'b1;
         best_len_in = rd_route.len;
         best_hop_in = rd_route.hop;
      end

      if (result_load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = '0;
         priority if (dest_ff == local_addr_ff) begin
            rsp_verdict_in = VERDICT_LOCAL;
         end else if (ttl_ff == '0) begin
            rsp_verdict_in = VERDICT_TTL_ERR;
         end else if (found_ff) begin
            rsp_verdict_in = VERDICT_FORWARD;
            rsp_data_in    = {~sum_ff, ttl_ff - TTL_W'(1), best_hop_ff};
         end else begin
            rsp_verdict_in = VERDICT_NO_ROUTE;
         end
         widx_in = '0;
         ihl_in  = '0;
         ttl_in  = '0;
         dest_in = '0;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         local_addr_ff <= '0;
         count_ff      <= '0;
         widx_ff       <= '0;
         ihl_ff        <= '0;
         ttl_ff        <= '0;
         dest_ff       <= '0;
         sum_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            local_addr_ff <= csr_wr_data;
         end
         count_ff      <= count_in;
         widx_ff       <= widx_in;
         ihl_ff        <= ihl_in;
         ttl_ff        <= ttl_in;
         dest_ff       <= dest_in;
         sum_ff        <= sum_in;
         rd_vld_ff     <= rd_vld_in;
         found_ff      <= found_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      scan_ff        <= scan_in;
      best_len_ff    <= best_len_in;
      best_hop_ff    <= best_hop_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_verdict_ff;

   // the table never grows past its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("route count overflow");

   // the sweep never reads past the filled part of the table
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= count_ff))
      else $error("route sweep past count");

   // a new result only comes out of the result state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == S_RESULT))
      else $error("result without sweep");

   // per-packet state is clear once a result is issued
   a_pkt_clear: assert property (@(posedge clock) disable iff (reset)
      result_load |=> (widx_ff == '0) && (sum_ff == '0) && (dest_ff == '0))
      else $error("header state not cleared");

   // RAM writes only happen while header/add beats are taken
   a_wr_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE) && !rd_vld_ff)
      else $error("table write during sweep");

endmodule
